// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define DLMJ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define DLMJ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define DLMJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DLMJ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define DLMJ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define DLMJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dlmj_pkg.sv =====
package dlmj_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CTRL_W   = 16;
    localparam int unsigned HYST_W   = 15;
    localparam int unsigned CFG_W    = 16;

    // The leaky average keeps 31/32 of the old value: 31 = 2^5 - 1.
    localparam int unsigned AVG_SHIFT = 5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] new_sample;
        logic        [CTRL_W-1:0]   delay_control;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       head_jumped;
        logic                       move_pending;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TGT,
        S_DEC
    } t_state;

    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HYST   = 2'd0;
    localparam t_cfg_idx CFG_SETTLE = 2'd1;
    localparam t_cfg_idx CFG_WINDOW = 2'd2;
    localparam t_cfg_idx CFG_OFFSET = 2'd3;

    localparam logic [HYST_W-1:0] HYST_RST   = 15'd64;
    localparam logic [CFG_W-1:0]  SETTLE_RST = 16'd1000;
    localparam logic [CFG_W-1:0]  WINDOW_RST = 16'd100;
    localparam logic [CFG_W-1:0]  OFFSET_RST = 16'd150;

endpackage

// ===== rtl/core/delay_line_with_matched_head_jump_core.sv =====
// Audio delay line with a click-free jump of the read head. Every input transfer stores
// one sample at the write head, returns the sample under the read head and advances both
// heads around a ring of BUFFER_DEPTH entries. The delay control reading, less
// control_offset, is smoothed with a 31/32 leaky average that is floored at zero and
// capped at BUFFER_DEPTH - 1. A smoothed change larger than delay_hysteresis starts a
// countdown of settle_ticks items; once it runs out the read head jumps to write head
// minus delay, but only on an item where the sample found there is within match_window
// of the last output and on the same side of it as the current sample, so the jump lands
// on a matching point of the waveform. Every input transfer gives exactly one output
// transfer. An item goes through accept, target read and decision; a new item enters
// only with the decision for the last one, which waits for a free output, as the single
// read port of the sample RAM is used twice per item, for the current sample and for
// the jump target. No clearing pass follows reset: the write head fills the ring in
// order, so a fill flag marks the written entries, and one never written reads as zero.
module delay_line_with_matched_head_jump_core #(
    parameter int unsigned BUFFER_DEPTH = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dlmj_pkg::t_in_item   i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dlmj_pkg::t_out_item  o_out_data,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  dlmj_pkg::t_cfg_idx   i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    `include "assert_macros.svh"

    // Ring address width. The smoothed delay never exceeds BUFFER_DEPTH - 1, so it
    // shares this width.
    localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
    // The average sum needs room for 31 times the delay plus a 16-bit reading, plus sign.
    localparam int unsigned SUM_W = ((AW > 16) ? AW : 16) + 7;
    localparam int unsigned AVG_W = SUM_W - dlmj_pkg::AVG_SHIFT;
    localparam int unsigned HW    = (AW > dlmj_pkg::HYST_W) ? AW : dlmj_pkg::HYST_W;
    localparam logic [AW-1:0]    LAST     = AW'(BUFFER_DEPTH - 1);
    localparam logic [AVG_W-1:0] AVG_MAX  = AVG_W'(BUFFER_DEPTH - 1);
    localparam logic [AW:0]      DEPTH_X  = (AW + 1)'(BUFFER_DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
        return (pos == LAST) ? '0 : pos + 1'b1;
    endfunction

    // Configuration registers.
    logic [dlmj_pkg::HYST_W-1:0] r_hyst;
    logic [15:0]                 r_settle;
    logic [15:0]                 r_window;
    logic [15:0]                 r_offset;

    // Sequencer and ring state.
    dlmj_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_wh;
    logic [AW-1:0]    r_rh;
    logic             r_wrap;       // the write head has gone once around the ring
    logic [AW-1:0]    r_smooth;
    logic [AW-1:0]    r_accept;
    logic [15:0]      r_cnt;
    logic             r_due;        // this item is the last countdown tick: try the jump
    logic signed [15:0] r_prev;

    // Per-item work registers.
    logic               r_cur_ok;
    logic signed [15:0] r_cur;
    logic [AW-1:0]      r_tgt;
    logic               r_tgt_ok;

    // Output register.
    logic                r_ovalid;
    dlmj_pkg::t_out_item r_out;

    // RAM connections.
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic in_fire;
    logic dec_go;

    // Decision stage signals.
    logic signed [15:0] cand;
    logic signed [16:0] gap;
    logic        [16:0] gap_mag;
    logic               side_ok;
    logic               jump;
    logic [15:0]        cnt_fwd;
    logic [AW-1:0]      rh_fwd;

    // Accept stage signals.
    logic signed [SUM_W-1:0] sum;
    logic [AVG_W-1:0]        avg;
    logic [AW-1:0]           n_smooth;
    logic [AW-1:0]           diff;
    logic                    arm;
    logic [15:0]             cnt_arm;
    logic [15:0]             n_cnt;

    // Target stage signals.
    logic [AW-1:0] tgt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst   <= dlmj_pkg::HYST_RST;
            r_settle <= dlmj_pkg::SETTLE_RST;
            r_window <= dlmj_pkg::WINDOW_RST;
            r_offset <= dlmj_pkg::OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dlmj_pkg::CFG_HYST:   r_hyst   <= i_cfg_data[dlmj_pkg::HYST_W-1:0];
                dlmj_pkg::CFG_SETTLE: r_settle <= i_cfg_data;
                dlmj_pkg::CFG_WINDOW: r_window <= i_cfg_data;
                dlmj_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The decision for an item can complete when the output register is free or is
    // being emptied in this cycle. A new item may enter in that same cycle, so the
    // accept stage sees the read head and countdown as the decision leaves them.
    assign dec_go     = (r_state == dlmj_pkg::S_DEC) && (!r_ovalid || i_out_ready);
    assign o_in_ready = (r_state == dlmj_pkg::S_IDLE) || dec_go;
    assign in_fire    = i_in_valid && o_in_ready;

    // Jump decision. The target sample arrives from the RAM read issued in S_TGT; an
    // entry the write head has not reached yet is read as zero.
    always_comb begin
        cand    = r_tgt_ok ? $signed(ram_rdata) : 16'sd0;
        gap     = {cand[15], cand} - {r_prev[15], r_prev};
        gap_mag = gap[16] ? 17'(-gap) : 17'(gap);
        side_ok = (cand >= r_prev) == (r_cur >= r_prev);
        jump    = r_due && (gap_mag < {1'b0, r_window}) && side_ok;
        cnt_fwd = (dec_go && jump) ? 16'd0 : r_cnt;
        rh_fwd  = (dec_go && jump) ? r_tgt : r_rh;
    end

    // Accept stage: leaky average, hysteresis and the countdown tick. The sum is
    // 31 * smoothed + reading - offset, and the floor division by 32 is a shift.
    always_comb begin
        sum = $signed(SUM_W'({r_smooth, 5'b0})) - $signed(SUM_W'(r_smooth))
            + $signed(SUM_W'(i_in_data.delay_control)) - $signed(SUM_W'(r_offset));
        avg = AVG_W'(sum >>> dlmj_pkg::AVG_SHIFT);
        if (sum[SUM_W-1]) begin
            n_smooth = '0;
        end else if (avg > AVG_MAX) begin
            n_smooth = LAST;
        end else begin
            n_smooth = avg[AW-1:0];
        end
        diff = (n_smooth >= r_accept) ? n_smooth - r_accept : r_accept - n_smooth;
        arm  = HW'(diff) > HW'(r_hyst);
        // A running countdown is not restarted by a new change.
        cnt_arm = (arm && (cnt_fwd == 16'd0)) ? r_settle : cnt_fwd;
        // The countdown holds at one until the jump finds a matching point.
        n_cnt   = (cnt_arm > 16'd1) ? cnt_arm - 16'd1 : cnt_arm;
    end

    // Target stage: write head (already advanced) minus the smoothed delay, on the ring.
    always_comb begin
        if ({1'b0, r_wh} >= {1'b0, r_smooth}) begin
            tgt = r_wh - r_smooth;
        end else begin
            tgt = AW'({1'b0, r_wh} + DEPTH_X - {1'b0, r_smooth});
        end
    end

    // The single read port serves the current sample on accept and the target in S_TGT.
    // The write on accept happens in the same cycle; the RAM returns the old contents, as
    // the read of the current sample comes before the store.
    assign ram_re    = in_fire || (r_state == dlmj_pkg::S_TGT);
    assign ram_raddr = (r_state == dlmj_pkg::S_TGT) ? tgt : rh_fwd;

    dlmj_ram #(
        .WIDTH (dlmj_pkg::SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_wh),
        .i_wdata (i_in_data.new_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dlmj_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = dlmj_pkg::S_TGT;
                end
            end
            dlmj_pkg::S_TGT: begin
                n_state = dlmj_pkg::S_DEC;
            end
            dlmj_pkg::S_DEC: begin
                if (dec_go) begin
                    n_state = in_fire ? dlmj_pkg::S_TGT : dlmj_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dlmj_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlmj_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring and control state. When a decision and an accept share a cycle, the accept
    // updates take over and already include the forwarded decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh     <= '0;
            r_rh     <= '0;
            r_wrap   <= 1'b0;
            r_smooth <= '0;
            r_accept <= '0;
            r_cnt    <= '0;
            r_due    <= 1'b0;
            r_prev   <= '0;
        end else begin
            if (dec_go) begin
                r_prev <= jump ? cand : r_cur;
            end
            if (in_fire) begin
                r_wh     <= ring_next(r_wh);
                r_rh     <= ring_next(rh_fwd);
                r_wrap   <= r_wrap || (r_wh == LAST);
                r_smooth <= n_smooth;
                if (arm) begin
                    r_accept <= n_smooth;
                end
                r_cnt <= n_cnt;
                r_due <= (cnt_arm == 16'd1);
            end else if (dec_go) begin
                r_cnt <= cnt_fwd;
                r_rh  <= rh_fwd;
            end
        end
    end

    // Per-item payload. An entry is valid once the write head has passed it.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cur_ok <= r_wrap || (rh_fwd < r_wh);
        end
        if (r_state == dlmj_pkg::S_TGT) begin
            r_cur    <= r_cur_ok ? $signed(ram_rdata) : 16'sd0;
            r_tgt    <= tgt;
            r_tgt_ok <= r_wrap || (tgt < r_wh);
        end
    end

    // Output register: holds a finished result while the next item is being worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (dec_go) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_go) begin
            r_out.out_sample   <= jump ? cand : r_cur;
            r_out.head_jumped  <= jump;
            r_out.move_pending <= (cnt_fwd != 16'd0);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // The RAM port is busy with the target read, so no item may enter then.
    `DLMJ_ASSERT_SAME(a_no_accept_in_tgt, i_clk, i_rst_n, r_state == dlmj_pkg::S_TGT, !o_in_ready, "item accepted during target read")
    // A jump attempt is only flagged while the countdown sits at its last tick.
    `DLMJ_ASSERT_SAME(a_due_at_one, i_clk, i_rst_n, r_due && r_state != dlmj_pkg::S_IDLE, r_cnt == 16'd1, "jump attempt without countdown at one")
    // Both heads stay inside the ring, also for depths that are not a power of two.
    `DLMJ_ASSERT_ALWAYS(a_heads_in_ring, i_clk, i_rst_n, (r_wh <= LAST) && (r_rh <= LAST), "ring head out of range")
    // Every accepted item moves the write head.
    `DLMJ_ASSERT_NEXT(a_wh_moves, i_clk, i_rst_n, in_fire, r_wh != $past(r_wh), "write head did not advance")

endmodule

// ===== rtl/core/dlmj_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read and a write to the same address in one cycle return the old data.
module dlmj_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
